/* hw/rtl/pol_pkg.sv */
// Shared types and constants for the positional ordered list.
// Used by the list cell, the list controller and the top level.
`timescale 1ns / 1ps

package pol_pkg;

   // List depth and derived widths.
   localparam int CAPACITY = 16;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // Field widths fixed by the item format.
   localparam int OP_W     = 3;
   localparam int VAL_W    = 32;
   localparam int POS_W    = 5;
   localparam int STATUS_W = 2;
   localparam int LEN_W    = 5;

   // Common compare width for positions against the entry count.
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   // Operation codes of an input item.
   typedef enum logic [OP_W-1:0] {
      OP_INS_HEAD = 3'd0,
      OP_INS_POS  = 3'd1,
      OP_INS_TAIL = 3'd2,
      OP_DEL_POS  = 3'd3,
      OP_DEL_HEAD = 3'd4,
      OP_DEL_TAIL = 3'd5,
      OP_DUMP     = 3'd6
   } op_type;

   // Status codes of a result item.
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2,
      STATUS_RANGE = 2'd3
   } status_type;

   // Per-cell load select: which source a cell takes this cycle.
   typedef enum logic [2:0] {
      SEL_HOLD,
      SEL_LEFT,
      SEL_RIGHT,
      SEL_NEW,
      SEL_WRAP
   } sel_type;

   // Control group from the controller to the cell chain.
   typedef struct packed {
      sel_type [CAPACITY-1:0] sel;
      logic [VAL_W-1:0]       new_value;
   } chain_cmd_type;

endpackage

/* hw/rtl/positional_ordered_list.sv */
// Top level of the positional ordered list: a chain of entry cells steered
// by the list controller. Depends on pol_pkg, pol_cell and pol_ctrl.
//
//   Channel   Direction   Ports
//   req_      in          req_valid, req_stall, req_operation, req_value, req_position
//   rsp_      out         rsp_valid, rsp_stall, rsp_status, rsp_entry_value,
//                         rsp_entry_valid, rsp_length, rsp_last
//
// An insert, a delete or any other non-dump item is accepted and its result is
// registered; the affected cells shift in the same cycle as it is registered.
// A dump enters the dump state, then gives one entry per cycle while rsp_ is not
// stalled, as the occupied cells rotate through the head cell to their original order.
// Reset empties the list; entry words are not cleared and are never read unwritten.
// A stall on rsp_ holds the result register and also stalls req_ and the dump.
`timescale 1ns / 1ps

module positional_ordered_list (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [pol_pkg::OP_W-1:0]      req_operation,
   input  logic signed [pol_pkg::VAL_W-1:0] req_value,
   input  logic [pol_pkg::POS_W-1:0]     req_position,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [pol_pkg::STATUS_W-1:0]  rsp_status,
   output logic signed [pol_pkg::VAL_W-1:0] rsp_entry_value,
   output logic                          rsp_entry_valid,
   output logic [pol_pkg::LEN_W-1:0]     rsp_length,
   output logic                          rsp_last
);
   import pol_pkg::*;

   chain_cmd_type    chain_cmd;
   logic [VAL_W-1:0] cell_data [CAPACITY];

   // Controller: decode, entry count and result register.
   pol_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_value       (req_value),
      .req_position    (req_position),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_entry_value (rsp_entry_value),
      .rsp_entry_valid (rsp_entry_valid),
      .rsp_length      (rsp_length),
      .rsp_last        (rsp_last),
      .head_data       (cell_data[0]),
      .chain_cmd       (chain_cmd)
   );

   // Row of cells; each one sees its two neighbors and the head for wrapping.
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [VAL_W-1:0] left_data;
      logic [VAL_W-1:0] right_data;

      if (g == 0) begin : g_first
         assign left_data = '0;
      end else begin : g_inner_left
         assign left_data = cell_data[g-1];
      end

      if (g == CAPACITY - 1) begin : g_last
         assign right_data = '0;
      end else begin : g_inner_right
         assign right_data = cell_data[g+1];
      end

      pol_cell u_cell (
         .clock      (clock),
         .sel        (chain_cmd.sel[g]),
         .left_data  (left_data),
         .right_data (right_data),
         .new_data   (chain_cmd.new_value),
         .wrap_data  (cell_data[0]),
         .data_out   (cell_data[g])
      );
   end

endmodule

/* hw/rtl/pol_cell.sv */
// One storage cell of the list chain: holds one entry word.
// Depends on pol_pkg for the load select type and the word width.
`timescale 1ns / 1ps

module pol_cell (
   input  logic                    clock,
   input  pol_pkg::sel_type        sel,
   input  logic [pol_pkg::VAL_W-1:0] left_data,
   input  logic [pol_pkg::VAL_W-1:0] right_data,
   input  logic [pol_pkg::VAL_W-1:0] new_data,
   input  logic [pol_pkg::VAL_W-1:0] wrap_data,
   output logic [pol_pkg::VAL_W-1:0] data_out
);
   import pol_pkg::*;

   logic [VAL_W-1:0] data_ff;
   logic [VAL_W-1:0] data_in;

   // Pick the source for this cycle.
   always_comb begin
      case (sel)
         SEL_LEFT:  data_in = left_data;
         SEL_RIGHT: data_in = right_data;
         SEL_NEW:   data_in = new_data;
         SEL_WRAP:  data_in = wrap_data;
         default:   data_in = data_ff;
      endcase
   end

   // The entry word is payload and needs no reset.
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;

endmodule

/* hw/rtl/pol_ctrl.sv */
// Controller of the list: decodes items, keeps the entry count, steers the
// cell chain and holds the result register. Depends on pol_pkg.
`timescale 1ns / 1ps

module pol_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [pol_pkg::OP_W-1:0]      req_operation,
   input  logic signed [pol_pkg::VAL_W-1:0] req_value,
   input  logic [pol_pkg::POS_W-1:0]     req_position,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [pol_pkg::STATUS_W-1:0]  rsp_status,
   output logic signed [pol_pkg::VAL_W-1:0] rsp_entry_value,
   output logic                          rsp_entry_valid,
   output logic [pol_pkg::LEN_W-1:0]     rsp_length,
   output logic                          rsp_last,
   input  logic [pol_pkg::VAL_W-1:0]     head_data,
   output pol_pkg::chain_cmd_type        chain_cmd
);
   import pol_pkg::*;

   typedef enum logic {
      STATE_IDLE,
      STATE_DUMP
   } state_type;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     remain_ff, remain_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [VAL_W-1:0]     rsp_value_ff, rsp_value_in;
   logic                 rsp_entry_valid_ff, rsp_entry_valid_in;
   logic [LEN_W-1:0]     rsp_length_ff, rsp_length_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 out_free;
   logic                 accept;
   op_type               op;
   logic [CMP_W-1:0]     cnt_x;
   logic [CMP_W-1:0]     pos_x;
   logic [CMP_W-1:0]     ins_pos;
   logic [CMP_W-1:0]     del_pos;
   logic                 ins_full;
   logic                 ins_range;
   logic                 del_empty;
   logic                 del_range;

   // Handshake: the result slot is free when empty or being taken.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff == STATE_DUMP) || !out_free;
   assign accept    = req_valid && !req_stall;
   assign op        = op_type'(req_operation);

   // Position decode and checks for inserts and deletes.
   always_comb begin
      cnt_x = CMP_W'(count_ff);
      pos_x = CMP_W'(req_position);
      case (op)
         OP_INS_HEAD: ins_pos = '0;
         OP_INS_TAIL: ins_pos = cnt_x;
         default:     ins_pos = pos_x;
      endcase
      case (op)
         OP_DEL_HEAD: del_pos = '0;
         OP_DEL_TAIL: del_pos = cnt_x;
         default:     del_pos = pos_x;
      endcase
      ins_full  = (cnt_x >= CMP_W'(CAPACITY));
      ins_range = (ins_pos > cnt_x);
      del_empty = (count_ff == '0);
      del_range = (del_pos > cnt_x);
      // Deleting at the position equal to the length removes the last entry.
      if (!del_empty && (del_pos == cnt_x)) begin
         del_pos = cnt_x - CMP_W'(1);
      end
   end

   // Next state, result register and per-cell selects.
   always_comb begin
      state_in           = state_ff;
      count_in           = count_ff;
      remain_in          = remain_ff;
      rsp_valid_in       = rsp_valid_ff && rsp_stall;
      rsp_status_in      = rsp_status_ff;
      rsp_value_in       = rsp_value_ff;
      rsp_entry_valid_in = rsp_entry_valid_ff;
      rsp_length_in      = rsp_length_ff;
      rsp_last_in        = rsp_last_ff;
      chain_cmd.new_value = $unsigned(req_value);
      for (int i = 0; i < CAPACITY; i++) begin
         chain_cmd.sel[i] = SEL_HOLD;
      end

      case (state_ff)
         STATE_IDLE: begin
            if (accept) begin
               rsp_valid_in       = 1'b1;
               rsp_status_in      = STATUS_OK;
               rsp_value_in       = '0;
               rsp_entry_valid_in = 1'b0;
               rsp_last_in        = 1'b1;
               case (op)
                  OP_INS_HEAD, OP_INS_POS, OP_INS_TAIL: begin
                     if (ins_full) begin
                        rsp_status_in = STATUS_FULL;
                     end else if (ins_range) begin
                        rsp_status_in = STATUS_RANGE;
                     end else begin
                        // Shift the tail right by one and drop in the new value.
                        for (int i = 0; i < CAPACITY; i++) begin
                           if (CMP_W'(i) == ins_pos) begin
                              chain_cmd.sel[i] = SEL_NEW;
                           end else if (CMP_W'(i) > ins_pos && CMP_W'(i) <= cnt_x) begin
                              chain_cmd.sel[i] = SEL_LEFT;
                           end
                        end
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  OP_DEL_POS, OP_DEL_HEAD, OP_DEL_TAIL: begin
                     if (del_empty) begin
                        rsp_status_in = STATUS_EMPTY;
                     end else if (del_range) begin
                        rsp_status_in = STATUS_RANGE;
                     end else begin
                        // Close the gap by shifting the tail left by one.
                        for (int i = 0; i < CAPACITY; i++) begin
                           if (CMP_W'(i) >= del_pos && CMP_W'(i) + CMP_W'(1) < cnt_x) begin
                              chain_cmd.sel[i] = SEL_RIGHT;
                           end
                        end
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  OP_DUMP: begin
                     if (del_empty) begin
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        // Entries stream out over the following cycles.
                        rsp_valid_in = 1'b0;
                        remain_in    = count_ff;
                        state_in     = STATE_DUMP;
                     end
                  end
                  default: begin
                     rsp_status_in = STATUS_OK;
                  end
               endcase
               rsp_length_in = LEN_W'(count_in);
            end
         end
         STATE_DUMP: begin
            if (out_free) begin
               // Emit the head entry and rotate the occupied cells by one.
               rsp_valid_in       = 1'b1;
               rsp_status_in      = STATUS_OK;
               rsp_value_in       = head_data;
               rsp_entry_valid_in = 1'b1;
               rsp_length_in      = LEN_W'(count_ff);
               rsp_last_in        = (remain_ff == CNT_W'(1));
               for (int i = 0; i < CAPACITY; i++) begin
                  if (CMP_W'(i) + CMP_W'(1) < cnt_x) begin
                     chain_cmd.sel[i] = SEL_RIGHT;
                  end else if (CMP_W'(i) + CMP_W'(1) == cnt_x) begin
                     chain_cmd.sel[i] = SEL_WRAP;
                  end
               end
               remain_in = remain_ff - CNT_W'(1);
               if (remain_ff == CNT_W'(1)) begin
                  state_in = STATE_IDLE;
               end
            end
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_IDLE;
         count_ff     <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff      <= rsp_status_in;
      rsp_value_ff       <= rsp_value_in;
      rsp_entry_valid_ff <= rsp_entry_valid_in;
      rsp_length_ff      <= rsp_length_in;
      rsp_last_ff        <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_value = $signed(rsp_value_ff);
   assign rsp_entry_valid = rsp_entry_valid_ff;
   assign rsp_length      = rsp_length_ff;
   assign rsp_last        = rsp_last_ff;

endmodule
